>>> rtl/core/pwsg_pkg.sv
// Shared types and constants of the price window signal generator.
`timescale 1ns / 1ps
package pwsg_pkg;

  // Port and register widths
  localparam int IN_PRICE_W = 32;
  localparam int SIG_W      = 2;
  localparam int STRAT_W    = 2;
  localparam int WLEN_W     = 7;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [STRAT_W-1:0] STRATEGY_RST  = 2'd0;
  localparam logic [WLEN_W-1:0]  WINDOW_RST    = 7'd20;
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 16'd1311;

  // Strategy codes
  localparam logic [STRAT_W-1:0] STRAT_MOMENTUM  = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_MEAN_REV  = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_BREAKOUT  = 2'd2;

  // Signal codes
  localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;
  localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
  localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

  // Decision constants
  localparam int MIN_WINDOW    = 2;
  localparam int RSI_W_SMALL   = 3;   // RSI 70 / 30 bounds as 3:7 ratios
  localparam int RSI_W_LARGE   = 7;
  localparam int DEV_FRAC_BITS = 16;  // Q0.16 threshold
  localparam int BRK_FACTOR    = 50;  // 2 % of the range
  localparam int BRK_GROW_W    = 6;   // bits added by the breakout factor

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_NEXT,
    ST_RD_OLD,
    ST_DIFF,
    ST_UPDATE,
    ST_MOM_MUL,
    ST_MOM_CMP,
    ST_MR_MUL,
    ST_MR_SUB,
    ST_MR_CMP,
    ST_BK_SCAN,
    ST_BK_LAST,
    ST_BK_SUB,
    ST_BK_MUL,
    ST_BK_CMP,
    ST_OUT
  } state_t;

endpackage

>>> rtl/core/pwsg_ring.sv
// Price ring memory: one write port, one registered read port.
`timescale 1ns / 1ps
module pwsg_ring #(
  parameter int DEPTH  = 65,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/price_window_signal_generator_unit.sv
// Top level of the price window signal generator.
`timescale 1ns / 1ps
// One price enters per transfer on in_valid/in_stall; one result (signal and
// window_ready) leaves per price on out_valid/out_stall. Registers are set
// through cfg_we/cfg_index/cfg_wdata; the user must do so only while the block
// is idle, as the block itself does not enforce it. Writing strategy or
// window_length empties the price history. The last W+1 prices sit in a ring
// memory with one write and one read port; the running sums of prices, gains
// and losses are registers updated by read-modify-write of the ring entries
// that leave and enter the window. Each price passes through ring reads, a
// difference step, the sum update and the output step; momentum adds multiply
// and compare steps, mean reversion multiply, subtract and compare steps, and
// breakout a scan of the W+1 ring entries through the one read port, then
// last, subtract, multiply and compare steps, W being the effective window
// length. While the window fills, or for the unused strategy code, no
// strategy steps run. The result is loaded into an output register; the next
// price is taken while that register still waits on out_stall, and the block
// holds in its last step only if a finished result finds the register still
// occupied. Reset (synchronous, rst_n low) restores the register defaults and
// empties the history; the ring itself needs no clearing pass.
module price_window_signal_generator_unit #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pwsg_pkg::IN_PRICE_W-1:0]   in_price,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pwsg_pkg::SIG_W-1:0]        out_signal,
  output logic                              out_window_ready,
  input  logic                              cfg_we,
  input  logic [pwsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwsg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(MAX_WINDOW + 2);
  localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int DEV_W = PRICE_BITS + CNT_W;
  localparam int MOM_W = SUM_W + 3;
  localparam int BRK_W = PRICE_BITS + pwsg_pkg::BRK_GROW_W;
  localparam int FRAC  = pwsg_pkg::DEV_FRAC_BITS;
  localparam int THR_W = pwsg_pkg::THR_W;

  // Registers
  logic [pwsg_pkg::STRAT_W-1:0] strategy_r;
  logic [pwsg_pkg::WLEN_W-1:0]  window_length_r;
  logic [THR_W-1:0]             threshold_r;

  // History state
  pwsg_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]      fill_r;
  logic [IDX_W-1:0]      wp_r;
  logic [IDX_W-1:0]      wpo_r;
  logic [SUM_W-1:0]      price_sum_r;
  logic [SUM_W-1:0]      gain_sum_r;
  logic [SUM_W-1:0]      loss_sum_r;
  logic [PRICE_BITS-1:0] last_p_r;

  // Item datapath
  logic [PRICE_BITS-1:0] p_in;
  logic [PRICE_BITS-1:0] p_r;
  logic [PRICE_BITS-1:0] o_r, o2_r;
  logic [PRICE_BITS-1:0] g_add_r, l_add_r, g_sub_r, l_sub_r, p_sub_r;
  logic                  ready_r;
  logic [pwsg_pkg::SIG_W-1:0] sig_r;
  logic [MOM_W-1:0]      g_small_r, g_large_r, l_small_r, l_large_r;
  logic [DEV_W-1:0]      a_r, d_r, bound_r;
  logic [SUM_W-1:0]      hi_r;
  logic [2*FRAC-1:0]     lo_r;
  logic                  pos_r;
  logic [PRICE_BITS-1:0] mx_r, mn_r;
  logic [IDX_W-1:0]      scan_idx_r, scan_prev_r;
  logic                  scan_v_r;
  logic [PRICE_BITS-1:0] up_r, dn_r, rng_r;
  logic                  gt_r, lt_r;
  logic [BRK_W-1:0]      up50_r, dn50_r;

  // Output register
  logic                       out_valid_r;
  logic [pwsg_pkg::SIG_W-1:0] out_signal_r;
  logic                       out_window_ready_r;

  // Ring port
  logic                  ring_we;
  logic [IDX_W-1:0]      ring_raddr;
  logic [PRICE_BITS-1:0] ring_rdata;

  // Derived control
  logic [31:0]      wl_ext;
  logic [CNT_W-1:0] w_eff, len, wp_ext;
  logic [IDX_W-1:0] nx;
  logic             has_prev, full, grown, ready_nxt, scan_last, out_free;

  generate
    if (PRICE_BITS <= pwsg_pkg::IN_PRICE_W) begin : g_price_cut
      assign p_in = in_price[PRICE_BITS-1:0];
    end else begin : g_price_ext
      assign p_in = {{(PRICE_BITS-pwsg_pkg::IN_PRICE_W){1'b0}}, in_price};
    end
  endgenerate

  always_comb begin
    wl_ext = 32'(window_length_r);
    if (wl_ext < 32'(pwsg_pkg::MIN_WINDOW)) begin
      w_eff = CNT_W'(pwsg_pkg::MIN_WINDOW);
    end else if (wl_ext > 32'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(wl_ext);
    end
  end

  assign len       = w_eff + CNT_W'(1);
  assign wp_ext    = CNT_W'(wp_r);
  assign nx        = (wp_ext + CNT_W'(1) == len) ? '0 : wp_r + IDX_W'(1);
  assign has_prev  = (fill_r != '0);
  assign full      = (fill_r >= len);
  assign grown     = (fill_r >= w_eff);
  assign ready_nxt = full || ((fill_r + CNT_W'(1)) == len);
  assign scan_last = (CNT_W'(scan_idx_r) == len - CNT_W'(1));
  assign out_free  = !out_valid_r || !out_stall;

  pwsg_ring #(
    .DEPTH (DEPTH),
    .DATA_W(PRICE_BITS)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(wp_r),
    .wdata(p_r),
    .raddr(ring_raddr),
    .rdata(ring_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwsg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    ring_we    = 1'b0;
    ring_raddr = wp_r;
    case (state_r)
      pwsg_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        ring_raddr = nx;
        if (in_valid) begin
          state_nxt = pwsg_pkg::ST_RD_NEXT;
        end
      end
      pwsg_pkg::ST_RD_NEXT: begin
        ring_raddr = wp_r;
        state_nxt  = pwsg_pkg::ST_RD_OLD;
      end
      pwsg_pkg::ST_RD_OLD: begin
        ring_we   = 1'b1;
        state_nxt = pwsg_pkg::ST_DIFF;
      end
      pwsg_pkg::ST_DIFF: begin
        state_nxt = pwsg_pkg::ST_UPDATE;
      end
      pwsg_pkg::ST_UPDATE: begin
        if (!ready_nxt) begin
          state_nxt = pwsg_pkg::ST_OUT;
        end else begin
          case (strategy_r)
            pwsg_pkg::STRAT_MOMENTUM: state_nxt = pwsg_pkg::ST_MOM_MUL;
            pwsg_pkg::STRAT_MEAN_REV: state_nxt = pwsg_pkg::ST_MR_MUL;
            pwsg_pkg::STRAT_BREAKOUT: state_nxt = pwsg_pkg::ST_BK_SCAN;
            default:                  state_nxt = pwsg_pkg::ST_OUT;
          endcase
        end
      end
      pwsg_pkg::ST_MOM_MUL: state_nxt = pwsg_pkg::ST_MOM_CMP;
      pwsg_pkg::ST_MOM_CMP: state_nxt = pwsg_pkg::ST_OUT;
      pwsg_pkg::ST_MR_MUL:  state_nxt = pwsg_pkg::ST_MR_SUB;
      pwsg_pkg::ST_MR_SUB:  state_nxt = pwsg_pkg::ST_MR_CMP;
      pwsg_pkg::ST_MR_CMP:  state_nxt = pwsg_pkg::ST_OUT;
      pwsg_pkg::ST_BK_SCAN: begin
        ring_raddr = scan_idx_r;
        if (scan_last) begin
          state_nxt = pwsg_pkg::ST_BK_LAST;
        end
      end
      pwsg_pkg::ST_BK_LAST: state_nxt = pwsg_pkg::ST_BK_SUB;
      pwsg_pkg::ST_BK_SUB:  state_nxt = pwsg_pkg::ST_BK_MUL;
      pwsg_pkg::ST_BK_MUL:  state_nxt = pwsg_pkg::ST_BK_CMP;
      pwsg_pkg::ST_BK_CMP:  state_nxt = pwsg_pkg::ST_OUT;
      pwsg_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = pwsg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pwsg_pkg::ST_IDLE;
    endcase
  end

  // Registers and history control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r      <= pwsg_pkg::STRATEGY_RST;
      window_length_r <= pwsg_pkg::WINDOW_RST;
      threshold_r     <= pwsg_pkg::THRESHOLD_RST;
      fill_r          <= '0;
      wp_r            <= '0;
      price_sum_r     <= '0;
      gain_sum_r      <= '0;
      loss_sum_r      <= '0;
    end else if (cfg_we && (cfg_index == pwsg_pkg::CFG_STRATEGY ||
                            cfg_index == pwsg_pkg::CFG_WINDOW)) begin
      if (cfg_index == pwsg_pkg::CFG_STRATEGY) begin
        strategy_r <= cfg_wdata[pwsg_pkg::STRAT_W-1:0];
      end else begin
        window_length_r <= cfg_wdata[pwsg_pkg::WLEN_W-1:0];
      end
      fill_r      <= '0;
      wp_r        <= '0;
      price_sum_r <= '0;
      gain_sum_r  <= '0;
      loss_sum_r  <= '0;
    end else begin
      if (cfg_we && cfg_index == pwsg_pkg::CFG_THRESHOLD) begin
        threshold_r <= cfg_wdata[THR_W-1:0];
      end
      if (state_r == pwsg_pkg::ST_UPDATE) begin
        gain_sum_r  <= gain_sum_r + SUM_W'(g_add_r) - SUM_W'(g_sub_r);
        loss_sum_r  <= loss_sum_r + SUM_W'(l_add_r) - SUM_W'(l_sub_r);
        price_sum_r <= price_sum_r + SUM_W'(p_r) - SUM_W'(p_sub_r);
        wp_r        <= nx;
        if (!full) begin
          fill_r <= fill_r + CNT_W'(1);
        end
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    case (state_r)
      pwsg_pkg::ST_IDLE: begin
        p_r <= p_in;
      end
      pwsg_pkg::ST_RD_NEXT: begin
        o2_r <= ring_rdata;
      end
      pwsg_pkg::ST_RD_OLD: begin
        o_r <= ring_rdata;
      end
      pwsg_pkg::ST_DIFF: begin
        g_add_r <= (has_prev && p_r > last_p_r) ? p_r - last_p_r : '0;
        l_add_r <= (has_prev && !(p_r > last_p_r)) ? last_p_r - p_r : '0;
        g_sub_r <= (full && o2_r > o_r) ? o2_r - o_r : '0;
        l_sub_r <= (full && !(o2_r > o_r)) ? o_r - o2_r : '0;
        p_sub_r <= grown ? o2_r : '0;
      end
      pwsg_pkg::ST_UPDATE: begin
        last_p_r <= p_r;
        wpo_r    <= wp_r;
        ready_r  <= ready_nxt;
        sig_r    <= pwsg_pkg::SIG_NONE;
      end
      pwsg_pkg::ST_MOM_MUL: begin
        g_small_r <= MOM_W'(gain_sum_r) * MOM_W'(pwsg_pkg::RSI_W_SMALL);
        g_large_r <= MOM_W'(gain_sum_r) * MOM_W'(pwsg_pkg::RSI_W_LARGE);
        l_small_r <= MOM_W'(loss_sum_r) * MOM_W'(pwsg_pkg::RSI_W_SMALL);
        l_large_r <= MOM_W'(loss_sum_r) * MOM_W'(pwsg_pkg::RSI_W_LARGE);
      end
      pwsg_pkg::ST_MOM_CMP: begin
        if (g_small_r == '0 && l_small_r == '0) begin
          sig_r <= pwsg_pkg::SIG_BUY;
        end else if (g_small_r > l_large_r) begin
          sig_r <= pwsg_pkg::SIG_SELL;
        end else if (g_large_r < l_small_r) begin
          sig_r <= pwsg_pkg::SIG_BUY;
        end
      end
      pwsg_pkg::ST_MR_MUL: begin
        a_r  <= {{PRICE_BITS{1'b0}}, w_eff} * {{CNT_W{1'b0}}, p_r};
        hi_r <= {{(SUM_W-THR_W){1'b0}}, threshold_r} *
                {{FRAC{1'b0}}, price_sum_r[SUM_W-1:FRAC]};
        lo_r <= {{FRAC{1'b0}}, threshold_r} * {{(2*FRAC-THR_W){1'b0}}, price_sum_r[FRAC-1:0]};
      end
      pwsg_pkg::ST_MR_SUB: begin
        pos_r   <= a_r > DEV_W'(price_sum_r);
        d_r     <= (a_r > DEV_W'(price_sum_r)) ? a_r - DEV_W'(price_sum_r)
                                               : DEV_W'(price_sum_r) - a_r;
        bound_r <= DEV_W'(hi_r) + DEV_W'(lo_r[2*FRAC-1:FRAC]);
      end
      pwsg_pkg::ST_MR_CMP: begin
        if (d_r > bound_r) begin
          sig_r <= pos_r ? pwsg_pkg::SIG_SELL : pwsg_pkg::SIG_BUY;
        end
      end
      pwsg_pkg::ST_BK_SUB: begin
        gt_r  <= p_r > mx_r;
        lt_r  <= p_r < mn_r;
        up_r  <= p_r - mx_r;
        dn_r  <= mn_r - p_r;
        rng_r <= mx_r - mn_r;
      end
      pwsg_pkg::ST_BK_MUL: begin
        up50_r <= BRK_W'(up_r) * BRK_W'(pwsg_pkg::BRK_FACTOR);
        dn50_r <= BRK_W'(dn_r) * BRK_W'(pwsg_pkg::BRK_FACTOR);
      end
      pwsg_pkg::ST_BK_CMP: begin
        if (gt_r && up50_r > BRK_W'(rng_r)) begin
          sig_r <= pwsg_pkg::SIG_BUY;
        end else if (lt_r && dn50_r > BRK_W'(rng_r)) begin
          sig_r <= pwsg_pkg::SIG_SELL;
        end
      end
      default: begin
      end
    endcase
  end

  // Breakout scan over the prior prices, skipping the entry just written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_v_r <= 1'b0;
    end else if (state_r == pwsg_pkg::ST_UPDATE) begin
      scan_v_r   <= 1'b0;
      scan_idx_r <= '0;
      mx_r       <= '0;
      mn_r       <= '1;
    end else begin
      scan_v_r <= (state_r == pwsg_pkg::ST_BK_SCAN);
      if (state_r == pwsg_pkg::ST_BK_SCAN) begin
        scan_prev_r <= scan_idx_r;
        scan_idx_r  <= scan_idx_r + IDX_W'(1);
      end
      if (scan_v_r && scan_prev_r != wpo_r) begin
        if (ring_rdata > mx_r) begin
          mx_r <= ring_rdata;
        end
        if (ring_rdata < mn_r) begin
          mn_r <= ring_rdata;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == pwsg_pkg::ST_OUT && out_free) begin
      out_valid_r        <= 1'b1;
      out_signal_r       <= sig_r;
      out_window_ready_r <= ready_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_signal       = out_signal_r;
  assign out_window_ready = out_window_ready_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pwsg_pkg::ST_IDLE |-> fill_r <= len)
    else $error("fill count beyond ring length");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_ext < len)
    else $error("write pointer outside ring");

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == pwsg_pkg::ST_OUT)
    else $error("result loaded outside output step");

  a_signal_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_signal_r != pwsg_pkg::SIG_NONE |-> out_window_ready_r)
    else $error("signal given before window full");

endmodule
